[rtl/core/q2e_pkg.sv]
package q2e_pkg;

  // Angle accumulator: Q30 radians, enough headroom for +-pi plus CORDIC sweep.
  localparam int ACC_W = 35;

  // Queue between front and back.
  localparam int Q_PTR_W = 2;
  localparam int Q_DEPTH = 1 << Q_PTR_W;

  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [ACC_W-1:0] PI_Q30      = 35'sd3373259426;

  // atan(2^-i) * 2^30, rounded down (entries 27 to 30 rounded up)
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic full;
    logic empty;
  } q2e_q_stat_t;

endpackage

[rtl/core/quaternion_to_euler_rpy_core.sv]
// Quaternion to roll / pitch / yaw (Z-Y-X Euler angles), fully pipelined.
// Input stream: one quaternion per transaction, in_tdata = {w, z, y, x},
// each QUAT_WIDTH-bit signed Q2.(QUAT_WIDTH-2), x in the lowest bits.
// Output stream: one transaction per input, in order. out_tdata carries roll
// and yaw in signed Q3.(ANGLE_WIDTH-3), pitch in signed Q2.(ANGLE_WIDTH-3)
// radians; out_tuser: gimbal-lock flag bit 0, all-zero-quaternion flag bit 1.
// Throughput: one transaction per cycle, sustained while out_tready is high.
// Every stage is its own register: 4 front stages (magnitude, normalize
// shift, products, sums), then the back: 2 stages of pitch factors, one
// square-root stage per root bit, a pre-rotation stage plus CORDIC_STEPS
// CORDIC stages, then the output reg.
// A 4-deep queue sits between front and back. When out_tready is low the back
// pipeline freezes; the front keeps taking transactions until the queue and
// its own stages are full, then in_tready drops. No transaction is dropped.
// Reset (rst_n low, synchronous) empties the pipeline and queue; there is no
// other state and no configuration.
module quaternion_to_euler_rpy_core #(
  parameter int QUAT_WIDTH   = 16,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // quat_x, quat_y, quat_z, quat_w from the lowest bit up, zero padded to bytes
  input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // roll_angle, pitch_angle, yaw_angle from the lowest bit up, zero padded
  output logic [((3*ANGLE_WIDTH-1+7)/8)*8-1:0] out_tdata,
  // pitch_clamped, degenerate from the lowest bit up
  output logic [1:0] out_tuser
);
  import q2e_pkg::*;

  localparam int QW  = QUAT_WIDTH;
  localparam int AW  = ANGLE_WIDTH;
  localparam int SW  = 2*QW + 1;          // width of the atan2 arguments
  localparam int ODW = ((3*AW-1+7)/8)*8;

  logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
  assign quat_x = in_tdata[QW-1:0];
  assign quat_y = in_tdata[2*QW-1:QW];
  assign quat_z = in_tdata[3*QW-1:2*QW];
  assign quat_w = in_tdata[4*QW-1:3*QW];

  q2e_q_stat_t   q_stat;
  logic          push, pop;
  logic [6*SW:0] push_data, pop_data;

  // front: normalization and product terms
  q2e_front #(.QW(QW), .SW(SW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .q_full(q_stat.full), .push(push), .push_data(push_data)
  );

  q2e_queue #(.W(6*SW+1)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data),
    .stat(q_stat)
  );

  logic signed [AW-1:0] roll_angle, yaw_angle;
  logic signed [AW-2:0] pitch_angle;
  logic                 pitch_clamped, degenerate;

  // back: square root for cos(pitch), three CORDIC vectoring pipelines
  q2e_back #(.QW(QW), .AW(AW), .CS(CORDIC_STEPS), .SW(SW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_stat.empty), .pop(pop), .item(pop_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
    .pitch_clamped(pitch_clamped), .degenerate(degenerate)
  );

  assign out_tdata = ODW'({yaw_angle, pitch_angle, roll_angle});
  assign out_tuser = {degenerate, pitch_clamped};

endmodule

[rtl/core/q2e_queue.sv]
module q2e_queue #(
  parameter int W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [W-1:0]         push_data,
  input  logic                 pop,
  output logic [W-1:0]         pop_data,
  output q2e_pkg::q2e_q_stat_t stat
);
  import q2e_pkg::*;

  logic [W-1:0]       slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

[rtl/core/q2e_front.sv]
module q2e_front #(
  parameter int QW = 16,
  parameter int SW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [QW-1:0] quat_x,
  input  logic signed [QW-1:0] quat_y,
  input  logic signed [QW-1:0] quat_z,
  input  logic signed [QW-1:0] quat_w,
  input  logic                 q_full,
  output logic                 push,
  output logic [6*SW:0]        push_data
);
  import q2e_pkg::*;

  localparam int KW = $clog2(QW);
  localparam logic [QW-1:0]   NORM   = QW'(1) << (QW-2);
  localparam logic [2*QW-1:0] NORM_W = (2*QW)'(NORM);

  logic en;

  // stage 1: magnitudes
  logic                 v1_r;
  logic signed [QW-1:0] q1_r [4];
  logic [QW-1:0]        m1_r;
  logic [QW-1:0]        mag [4];
  logic [QW-1:0]        m_c;

  // stage 2: block-normalized components
  logic                 v2_r, deg2_r;
  logic signed [QW-1:0] q2_r [4];
  logic [KW-1:0]        lk;
  logic signed [QW-1:0] qn [4];

  // stage 3: products xx yy zz ww wx yz wz xy wy zx
  logic                   v3_r, deg3_r;
  logic signed [2*QW-1:0] p3_r [10];

  // stage 4: atan2 arguments
  logic                 v4_r;
  logic [6*SW:0]        t4_r;
  logic signed [SW-1:0] n2, ry, rx, yy, yx, sp;

  assign en       = !q_full || !v4_r;
  assign in_ready = en;
  assign push     = v4_r && en;
  assign push_data = t4_r;

  always_comb begin
    mag[0] = quat_x[QW-1] ? QW'(-quat_x) : QW'(quat_x);
    mag[1] = quat_y[QW-1] ? QW'(-quat_y) : QW'(quat_y);
    mag[2] = quat_z[QW-1] ? QW'(-quat_z) : QW'(quat_z);
    mag[3] = quat_w[QW-1] ? QW'(-quat_w) : QW'(quat_w);
    m_c = mag[0];
    for (int i = 1; i < 4; i++) begin
      if (mag[i] > m_c) m_c = mag[i];
    end
  end

  // Largest left shift that keeps the peak magnitude at or below 2^(QW-2); a larger peak is shifted right by one.
  always_comb begin
    lk = '0;
    for (int k = 0; k <= QW-2; k++) begin
      if (((2*QW)'(m1_r) << k) <= NORM_W) lk = KW'(k);
    end
    for (int i = 0; i < 4; i++) begin
      qn[i] = (m1_r > NORM) ? (q1_r[i] >>> 1) : (q1_r[i] <<< lk);
    end
  end

  always_comb begin
    n2 = SW'(p3_r[0]) + SW'(p3_r[1]) + SW'(p3_r[2]) + SW'(p3_r[3]);
    ry = (SW'(p3_r[4]) + SW'(p3_r[5])) <<< 1;
    rx = n2 - ((SW'(p3_r[0]) + SW'(p3_r[1])) <<< 1);
    yy = (SW'(p3_r[6]) + SW'(p3_r[7])) <<< 1;
    yx = n2 - ((SW'(p3_r[1]) + SW'(p3_r[2])) <<< 1);
    sp = (SW'(p3_r[8]) - SW'(p3_r[9])) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_r[0] <= quat_x;
      q1_r[1] <= quat_y;
      q1_r[2] <= quat_z;
      q1_r[3] <= quat_w;
      m1_r    <= m_c;
      q2_r    <= qn;
      deg2_r  <= (m1_r == '0);
      deg3_r  <= deg2_r;
      p3_r[0] <= q2_r[0] * q2_r[0];
      p3_r[1] <= q2_r[1] * q2_r[1];
      p3_r[2] <= q2_r[2] * q2_r[2];
      p3_r[3] <= q2_r[3] * q2_r[3];
      p3_r[4] <= q2_r[3] * q2_r[0];
      p3_r[5] <= q2_r[1] * q2_r[2];
      p3_r[6] <= q2_r[3] * q2_r[2];
      p3_r[7] <= q2_r[0] * q2_r[1];
      p3_r[8] <= q2_r[3] * q2_r[1];
      p3_r[9] <= q2_r[2] * q2_r[0];
      t4_r    <= {deg3_r, n2, sp, ry, rx, yy, yx};
    end
  end

endmodule

[rtl/core/q2e_cordic.sv]
module q2e_cordic #(
  parameter int IW    = 33,
  parameter int STEPS = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [IW-1:0]                  y_in,
  input  logic signed [IW-1:0]                  x_in,
  output logic signed [q2e_pkg::ACC_W-1:0]      ang
);
  import q2e_pkg::*;

  localparam int CW = IW + 2;

  logic signed [CW-1:0]    x_r [STEPS+1];
  logic signed [CW-1:0]    y_r [STEPS+1];
  logic signed [ACC_W-1:0] a_r [STEPS+1];
  logic [STEPS:0]          z_r;

  logic signed [CW-1:0]    xs, ys, x0, y0;
  logic signed [ACC_W-1:0] a0;

  // pre-rotation by +-pi/2 into the right half plane
  always_comb begin
    xs = CW'(x_in);
    ys = CW'(y_in);
    x0 = xs;
    y0 = ys;
    a0 = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0 = ys;
        y0 = -xs;
        a0 = HALF_PI_Q30;
      end else begin
        x0 = -ys;
        y0 = xs;
        a0 = -HALF_PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= x0;
      y_r[0] <= y0;
      a_r[0] <= a0;
      z_r[0] <= (x_in == '0) && (y_in == '0);
      z_r[STEPS:1] <= z_r[STEPS-1:0];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0]    dx, dy;
    logic signed [ACC_W-1:0] t;
    assign dx = x_r[i] >>> i;
    assign dy = y_r[i] >>> i;
    assign t  = {{(ACC_W-32){1'b0}}, ATAN_Q30[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - dy;
          y_r[i+1] <= y_r[i] + dx;
          a_r[i+1] <= a_r[i] - t;
        end else begin
          x_r[i+1] <= x_r[i] + dy;
          y_r[i+1] <= y_r[i] - dx;
          a_r[i+1] <= a_r[i] + t;
        end
      end
    end
  end

  assign ang = z_r[STEPS] ? '0 : a_r[STEPS];

endmodule

[rtl/core/q2e_back.sv]
module q2e_back #(
  parameter int QW = 16,
  parameter int AW = 16,
  parameter int CS = 16,
  parameter int SW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  output logic                 pop,
  input  logic [6*SW:0]        item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [AW-1:0] roll_angle,
  output logic signed [AW-2:0] pitch_angle,
  output logic signed [AW-1:0] yaw_angle,
  output logic                 pitch_clamped,
  output logic                 degenerate
);
  import q2e_pkg::*;

  localparam int UW  = 2*QW;
  localparam int PRW = 4*QW - 2;
  localparam int SQ  = 2*QW - 1;
  localparam int CL  = CS + 1;
  localparam int SBW = 3 + 5*SW;
  localparam int SH  = 33 - AW;
  localparam logic signed [ACC_W-1:0] RND      = ACC_W'(longint'(1) << (SH-1));
  localparam logic signed [ACC_W-1:0] LIM_PI   = (PI_Q30 + RND) >>> SH;
  localparam logic signed [ACC_W-1:0] LIM_HALF = (HALF_PI_Q30 + RND) >>> SH;

  function automatic logic signed [ACC_W-1:0] fmt(input logic signed [ACC_W-1:0] a,
                                                  input logic signed [ACC_W-1:0] lim);
    logic signed [ACC_W-1:0] r;
    r = (a + RND) >>> SH;
    if (r > lim) r = lim;
    else if (r < -lim) r = -lim;
    return r;
  endfunction

  logic en;
  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;

  // queue item
  logic                 i_deg;
  logic signed [SW-1:0] i_n2, i_s, i_ry, i_rx, i_yy, i_yx, i_as;
  logic                 i_clamp;
  assign {i_deg, i_n2, i_s, i_ry, i_rx, i_yy, i_yx} = item;
  assign i_as    = i_s[SW-1] ? -i_s : i_s;
  assign i_clamp = (i_as >= i_n2);

  // B0 / B1: cosine-squared factors and their product
  logic           v0_r, v1_r;
  logic [SBW-1:0] sb0_r, sb1_r;
  logic [UW-1:0]  d1_r, d2_r;
  logic [2*UW-1:0] prod_full;
  logic [PRW-1:0] prod_r;
  assign prod_full = d1_r * d2_r;

  // integer square root, one result bit per stage
  logic [PRW-1:0] sv_r [SQ];
  logic [PRW-1:0] sr_r [SQ];
  logic [PRW-1:0] nv_c [SQ];
  logic [PRW-1:0] nr_c [SQ];
  logic [SBW-1:0] sb_r [SQ];
  logic [SQ-1:0]  vs_r;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    localparam logic [PRW-1:0] BIT = PRW'(1) << (2*(SQ-1-g));
    logic [PRW-1:0] vi, ri;
    logic [PRW:0]   rb;
    logic           ge;
    if (g == 0) begin : g_first
      assign vi = prod_r;
      assign ri = '0;
    end else begin : g_rest
      assign vi = sv_r[g-1];
      assign ri = sr_r[g-1];
    end
    assign rb      = {1'b0, ri} + {1'b0, BIT};
    assign ge      = ({1'b0, vi} >= rb);
    assign nv_c[g] = ge ? PRW'({1'b0, vi} - rb) : vi;
    assign nr_c[g] = ge ? (ri >> 1) + BIT : (ri >> 1);
  end

  // after the square root
  logic                 q_deg, q_clamp, q_spos;
  logic signed [SW-1:0] q_s, q_ry, q_rx, q_yy, q_yx, q_c;
  assign {q_deg, q_clamp, q_spos, q_s, q_ry, q_rx, q_yy, q_yx} = sb_r[SQ-1];
  assign q_c = SW'({1'b0, sr_r[SQ-1][2*QW-2:0]});

  logic signed [ACC_W-1:0] roll_a, yaw_a, pitch_a;

  q2e_cordic #(.IW(SW), .STEPS(CS)) u_roll (
    .clk(clk), .en(en), .y_in(q_ry), .x_in(q_rx), .ang(roll_a)
  );
  q2e_cordic #(.IW(SW), .STEPS(CS)) u_yaw (
    .clk(clk), .en(en), .y_in(q_yy), .x_in(q_yx), .ang(yaw_a)
  );
  q2e_cordic #(.IW(SW), .STEPS(CS)) u_pitch (
    .clk(clk), .en(en), .y_in(q_s), .x_in(q_c), .ang(pitch_a)
  );

  // flags riding alongside the CORDIC stages: {deg, clamp, spos}
  logic [2:0]    cf_r [CL];
  logic [CL-1:0] cv_r;
  logic          c_deg, c_clamp, c_spos;
  assign {c_deg, c_clamp, c_spos} = cf_r[CL-1];

  logic signed [ACC_W-1:0] roll_f, yaw_f, pitch_f;
  always_comb begin
    roll_f = fmt(roll_a, LIM_PI);
    yaw_f  = fmt(yaw_a, LIM_PI);
    if (c_clamp) pitch_f = c_spos ? LIM_HALF : -LIM_HALF;
    else         pitch_f = fmt(pitch_a, LIM_HALF);
    if (c_deg) begin
      roll_f  = '0;
      yaw_f   = '0;
      pitch_f = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      vs_r      <= '0;
      cv_r      <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0_r      <= !q_empty;
      v1_r      <= v0_r;
      vs_r      <= {vs_r[SQ-2:0], v1_r};
      cv_r      <= {cv_r[CL-2:0], vs_r[SQ-1]};
      out_valid <= cv_r[CL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb0_r <= {i_deg, i_clamp, (i_s > 0), i_s, i_ry, i_rx, i_yy, i_yx};
      d1_r  <= i_clamp ? '0 : UW'(i_n2 - i_as);
      d2_r  <= i_clamp ? '0 : UW'(i_n2 + i_as);
      sb1_r <= sb0_r;
      prod_r <= PRW'(prod_full);
      sb_r[0] <= sb1_r;
      for (int g = 0; g < SQ; g++) begin
        sv_r[g] <= nv_c[g];
        sr_r[g] <= nr_c[g];
      end
      for (int g = 1; g < SQ; g++) begin
        sb_r[g] <= sb_r[g-1];
      end
      cf_r[0] <= {q_deg, q_clamp && !q_deg, q_spos};
      for (int g = 1; g < CL; g++) begin
        cf_r[g] <= cf_r[g-1];
      end
      roll_angle    <= AW'(roll_f);
      yaw_angle     <= AW'(yaw_f);
      pitch_angle   <= (AW-1)'(pitch_f);
      pitch_clamped <= c_clamp;
      degenerate    <= c_deg;
    end
  end

endmodule
